FILE: rtl/core/itoar_pkg.sv
// ============================================================================
// itoar_pkg - shared types and constants for the integer to ASCII converter
// Field widths, digit counts, the sequencer control word and the digit to
// character lookup.
// ============================================================================
package itoar_pkg;

    localparam int VALUE_W     = 64;
    localparam int NUM_DIGITS  = 20;              // decimal digits of 2^64 - 1
    localparam int HEX_DIGITS  = VALUE_W / 4;
    localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
    localparam int CNT_W       = $clog2(NUM_DIGITS + 1);
    localparam int BIT_CNT_W   = $clog2(VALUE_W);
    localparam int CHAR_W      = 7;
    localparam int TDATA_IN_W  = 64;
    localparam int TUSER_IN_W  = 2;
    localparam int TDATA_OUT_W = 8;

    // tuser bit positions on the input side
    localparam int TUSER_HEX = 0;
    localparam int TUSER_SGN = 1;

    localparam logic [CHAR_W-1:0] MINUS_CHAR = 7'h2D;

    // control word from the sequencer to the shift/correct register
    typedef struct packed {
        logic load;     // clear digits, restart the digit count
        logic shift;    // take one value bit
        logic dec;      // apply the add-3 correction (decimal)
        logic bit_in;   // value bit, most significant first
    } t_dab_ctrl;

    // map a digit to '0'-'9' or 'a'-'f'
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = 7'h30 + {3'b000, d};
        end else begin
            c = 7'h57 + {3'b000, d};
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/integer_to_ascii_radix_top.sv
// ============================================================================
// integer_to_ascii_radix_top - 64-bit integer to ASCII text, decimal or hex
// Converts one number per input word into a run of characters, optional
// minus sign first, most significant digit first, last character marked.
// ============================================================================
// Flow: an accepted number runs through the shift-and-add-3 bit loop, one bit
//   per cycle; a negative number then emits a minus sign, and then its digits
//   follow one per free output slot, d = 1..20 digits (1..16 in hex). A new
//   number is accepted only after the last digit is loaded for output.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle and
//   empties the output register; digit storage is cleared at each accept.
module integer_to_ascii_radix_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input word
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [itoar_pkg::TDATA_IN_W-1:0]  i_s_tdata,  // [63:0] value
    input  logic [itoar_pkg::TUSER_IN_W-1:0]  i_s_tuser,  // [0] hex_mode, [1] signed_mode
    // output word
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [itoar_pkg::TDATA_OUT_W-1:0] o_m_tdata,  // [6:0] ascii_char, [7] zero
    output logic                              o_m_tlast   // last
);
    import itoar_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SIGN = 4'b0100,
        S_DIG  = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [VALUE_W-1:0]    r_mag, n_mag;
    logic                  r_neg, n_neg;
    logic                  r_hex, n_hex;
    logic [BIT_CNT_W-1:0]  r_bit_cnt, n_bit_cnt;
    logic [DIGIT_IDX_W-1:0] r_idx, n_idx;
    logic                  r_ovalid, n_ovalid;
    logic [CHAR_W-1:0]     r_ochar, n_ochar;
    logic                  r_olast, n_olast;

    t_dab_ctrl             w_ctrl;
    logic [3:0]            w_digit;
    logic [CNT_W-1:0]      w_cnt;
    logic                  w_s_accept;
    logic                  w_out_free;
    logic                  w_out_load;
    logic                  w_in_neg;

    // the digit register: one value bit per cycle
    itoar_dabble u_dabble (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_rd_idx (r_idx),
        .o_digit  (w_digit),
        .o_cnt    (w_cnt)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign w_s_accept = i_s_tvalid && o_s_tready;
    // the output register may take a new word when empty or being drained
    assign w_out_free = !r_ovalid || i_m_tready;
    assign w_in_neg   = i_s_tuser[TUSER_SGN] && i_s_tdata[VALUE_W-1];

    always_comb begin
        n_state    = r_state;
        n_mag      = r_mag;
        n_neg      = r_neg;
        n_hex      = r_hex;
        n_bit_cnt  = r_bit_cnt;
        n_idx      = r_idx;
        n_ochar    = r_ochar;
        n_olast    = r_olast;
        w_out_load = 1'b0;
        w_ctrl     = '0;
        w_ctrl.dec = !r_hex;

        unique case (r_state)
            S_IDLE: begin
                if (w_s_accept) begin
                    // take the magnitude; the most negative value negates to itself,
                    // which read unsigned is exactly 2^63
                    n_mag       = w_in_neg ? (VALUE_W'(0) - i_s_tdata) : i_s_tdata;
                    n_neg       = w_in_neg;
                    n_hex       = i_s_tuser[TUSER_HEX];
                    n_bit_cnt   = '0;
                    w_ctrl.load = 1'b1;
                    n_state     = S_CONV;
                end
            end
            S_CONV: begin
                // feed the magnitude in, most significant bit first
                w_ctrl.shift  = 1'b1;
                w_ctrl.bit_in = r_mag[VALUE_W-1];
                n_mag         = {r_mag[VALUE_W-2:0], 1'b0};
                n_bit_cnt     = r_bit_cnt + BIT_CNT_W'(1);
                if (r_bit_cnt == BIT_CNT_W'(VALUE_W - 1)) begin
                    n_state = S_SIGN;
                end
            end
            S_SIGN: begin
                // point at the most significant digit; emit the sign if needed
                if (!r_neg) begin
                    n_idx   = DIGIT_IDX_W'(w_cnt - CNT_W'(1));
                    n_state = S_DIG;
                end else if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_ochar    = MINUS_CHAR;
                    n_olast    = 1'b0;
                    n_idx      = DIGIT_IDX_W'(w_cnt - CNT_W'(1));
                    n_state    = S_DIG;
                end
            end
            S_DIG: begin
                // one digit per free output slot, down to digit zero
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_ochar    = digit_char(w_digit);
                    n_olast    = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx - DIGIT_IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_out_load) begin
            n_ovalid = 1'b1;
        end else if (i_m_tready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bit_cnt <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_bit_cnt <= n_bit_cnt;
            r_ovalid  <= n_ovalid;
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_hex   <= n_hex;
        r_idx   <= n_idx;
        r_ochar <= n_ochar;
        r_olast <= n_olast;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {1'b0, r_ochar};
    assign o_m_tlast  = r_olast;

`ifndef SYNTH
    // an accepted word always starts the bit loop
    a_accept_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_accept |=> (r_state == S_CONV))
        else $error("accepted word did not start conversion");

    // the digit count fits the radix once the loop is done
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SIGN) |-> ((w_cnt >= CNT_W'(1)) &&
            (w_cnt <= (r_hex ? CNT_W'(HEX_DIGITS) : CNT_W'(NUM_DIGITS)))))
        else $error("digit count out of range");

    // the read pointer stays within the significant digits
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIG) |-> (CNT_W'(r_idx) < w_cnt))
        else $error("digit pointer beyond significant digits");

    // decimal correction keeps every digit in 0..9
    a_dec_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIG) && !r_hex) |-> (w_digit <= 4'd9))
        else $error("decimal digit above nine");

    // the final digit is marked last and the sequencer returns to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIG) && w_out_free && (r_idx == '0)) |=>
            ((r_state == S_IDLE) && r_ovalid && r_olast))
        else $error("final digit not marked last");
`endif

endmodule

FILE: rtl/core/itoar_dabble.sv
// ============================================================================
// itoar_dabble - bit-serial shift-and-add-3 digit register
// Takes one value bit per shift cycle, most significant first. In decimal mode
// each nibble is corrected before the shift; in hex mode the nibbles are the
// raw value. Tracks the number of significant digits as they appear.
// ============================================================================
module itoar_dabble (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  itoar_pkg::t_dab_ctrl             i_ctrl,
    input  logic [itoar_pkg::DIGIT_IDX_W-1:0] i_rd_idx,
    output logic [3:0]                       o_digit,
    output logic [itoar_pkg::CNT_W-1:0]      o_cnt
);
    import itoar_pkg::*;

    logic [3:0]       r_bcd [NUM_DIGITS];
    logic [3:0]       n_bcd [NUM_DIGITS];
    logic [3:0]       w_cor [NUM_DIGITS];
    logic [NUM_DIGITS-1:0] r_act;
    logic [NUM_DIGITS-1:0] n_act;
    logic [CNT_W-1:0] r_cnt;
    logic             w_grow;

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (i_ctrl.dec && (r_bcd[i] >= 4'd5)) begin
                w_cor[i] = r_bcd[i] + 4'd3;
            end else begin
                w_cor[i] = r_bcd[i];
            end
        end
    end

    // shift one bit through the corrected nibbles; mark a nibble active
    // once a carry reaches it
    always_comb begin
        w_grow   = 1'b0;
        n_bcd[0] = {w_cor[0][2:0], i_ctrl.bit_in};
        n_act[0] = 1'b1;
        for (int i = 1; i < NUM_DIGITS; i++) begin
            n_bcd[i] = {w_cor[i][2:0], w_cor[i-1][3]};
            n_act[i] = r_act[i] | (r_act[i-1] & w_cor[i-1][3]);
            w_grow   = w_grow | (r_act[i-1] & ~r_act[i] & w_cor[i-1][3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_bcd[i] <= 4'd0;
            end
        end else if (i_ctrl.shift) begin
            r_bcd <= n_bcd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= {{(NUM_DIGITS-1){1'b0}}, 1'b1};
            r_cnt <= CNT_W'(1);
        end else if (i_ctrl.load) begin
            r_act <= {{(NUM_DIGITS-1){1'b0}}, 1'b1};
            r_cnt <= CNT_W'(1);
        end else if (i_ctrl.shift) begin
            r_act <= n_act;
            if (w_grow) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    assign o_digit = r_bcd[i_rd_idx];
    assign o_cnt   = r_cnt;

endmodule

FILE: tb/tb_integer_to_ascii_radix_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_integer_to_ascii_radix_top - self-checking bench for the number to text
// converter
// Drives 64-bit numbers with every radix and sign setting. Directed extremes
// come first, then random numbers of mixed lengths. A local predictor
// produces the expected character run for each accepted word. Every output
// word is checked in order against it, with random and then no stream idling.
// ============================================================================
module tb_integer_to_ascii_radix_top;

    import itoar_pkg::*;

    // no word may be missing for this long
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 120;     // one full conversion and then some
    localparam int MAX_PRINTED  = 40;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_text_char;

    logic                   i_clk;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [TDATA_IN_W-1:0]  i_s_tdata  = '0;   // [63:0] value
    logic [TUSER_IN_W-1:0]  i_s_tuser  = '0;   // [0] hex_mode, [1] signed_mode
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] o_m_tdata;         // [6:0] ascii_char, [7] zero
    logic                   o_m_tlast;         // last

    t_text_char pending_chars[$];  // characters still owed by the block, oldest first
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         error_count   = 0;
    int         numbers_sent  = 0;
    int         chars_checked = 0;
    int         stall_cycles  = 0;

    integer_to_ascii_radix_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor: build the text of one number and queue it character by
    // character. A negative signed number gets a leading minus and then the
    // digits of its 64-bit unsigned negation, so the most negative value
    // comes out in full. Zero is never negative and gives a lone '0'.
    // ------------------------------------------------------------------------
    function automatic void predict_text(input logic [63:0] value, input logic hex,
                                         input logic sgn);
        logic [63:0]       mag;
        logic [3:0]        digit;
        logic [CHAR_W-1:0] digits_rev[$];
        t_text_char        c;
        mag = value;
        if (sgn && value[63]) begin
            c.ch   = MINUS_CHAR;
            c.last = 1'b0;
            pending_chars.push_back(c);
            mag = -value;
        end
        // peel digits off the low end, then emit them most significant first
        do begin
            if (hex) begin
                digit = mag[3:0];
                mag   = mag >> 4;
            end else begin
                digit = 4'(mag % 64'd10);
                mag   = mag / 64'd10;
            end
            digits_rev.push_back((digit < 4'd10) ? 7'h30 + 7'(digit)
                                                  : 7'h61 + 7'(digit) - 7'd10);
        end while (mag != 0);
        while (digits_rev.size() > 0) begin
            c.ch   = digits_rev.pop_back();
            c.last = (digits_rev.size() == 0);
            pending_chars.push_back(c);
        end
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("[%0t] MISMATCH: %s", $realtime, what);
        end
    endtask

    // ------------------------------------------------------------------------
    // Send one number. Hold valid low for a random number of cycles first,
    // then hold the word until the block takes it. Valid is left high after
    // the handshake so back-to-back words need no second assignment.
    // ------------------------------------------------------------------------
    task automatic push_number(input logic [63:0] value, input logic hex,
                               input logic sgn);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid           <= 1'b1;
        i_s_tdata            <= value;
        i_s_tuser[TUSER_HEX] <= hex;
        i_s_tuser[TUSER_SGN] <= sgn;
        do @(posedge i_clk); while (!o_s_tready);
        predict_text(value, hex, sgn);
        numbers_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: randomly drop ready, and compare every accepted word with the
    // oldest owed character.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_text_char exp_c;
        if (i_rst_n) begin
            i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (o_m_tvalid && i_m_tready) begin
                chars_checked++;
                if (pending_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected word char=0x%02h last=%0b",
                                              o_m_tdata[CHAR_W-1:0], o_m_tlast));
                end else begin
                    exp_c = pending_chars.pop_front();
                    if (o_m_tdata[CHAR_W-1:0] !== exp_c.ch) begin
                        report_mismatch($sformatf("char 0x%02h, want 0x%02h",
                                                  o_m_tdata[CHAR_W-1:0], exp_c.ch));
                    end
                    if (o_m_tlast !== exp_c.last) begin
                        report_mismatch($sformatf("last %0b, want %0b on char 0x%02h",
                                                  o_m_tlast, exp_c.last, exp_c.ch));
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[%0t] watchdog: no word moved in %0d cycles",
                         $realtime, STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------------

    // zero in every radix and sign setting: never a minus, always a lone '0'
    task automatic test_zero;
        push_number(64'd0, 1'b0, 1'b0);
        push_number(64'd0, 1'b1, 1'b0);
        push_number(64'd0, 1'b0, 1'b1);
        push_number(64'd0, 1'b1, 1'b1);
    endtask

    // widest runs, most negative value, largest positive, minus one
    task automatic test_extremes;
        push_number('1, 1'b0, 1'b0);                      // 20 decimal digits
        push_number('1, 1'b1, 1'b0);                      // 16 hex digits
        push_number('1, 1'b0, 1'b1);                      // -1
        push_number('1, 1'b1, 1'b1);                      // -1 in hex
        push_number(64'h8000_0000_0000_0000, 1'b0, 1'b1); // most negative
        push_number(64'h8000_0000_0000_0000, 1'b1, 1'b1);
        push_number(64'h8000_0000_0000_0000, 1'b0, 1'b0);
        push_number(64'h7fff_ffff_ffff_ffff, 1'b0, 1'b1); // largest positive
        push_number(64'h7fff_ffff_ffff_ffff, 1'b1, 1'b1);
        push_number(64'd10_000_000_000_000_000_000, 1'b0, 1'b0);
        push_number(64'hfedc_ba98_7654_3210, 1'b1, 1'b1); // negative in hex
    endtask

    // digit boundaries and every digit character in both radixes
    task automatic test_digit_boundaries;
        push_number(64'd9, 1'b0, 1'b0);
        push_number(64'd10, 1'b0, 1'b1);
        push_number(64'd15, 1'b1, 1'b0);
        push_number(64'd16, 1'b1, 1'b1);
        push_number(64'd1234567890, 1'b0, 1'b0);
        push_number(64'h0123_4567_89ab_cdef, 1'b1, 1'b0);
        push_number(64'hfedc_ba98_7654_3210, 1'b1, 1'b0);
        push_number(-64'd99999, 1'b0, 1'b1);
    endtask

    // random numbers of mixed length and sign, all radix and sign settings
    task automatic test_random_numbers(input int count);
        logic [63:0] value;
        for (int n = 0; n < count; n++) begin
            value = {$urandom(), $urandom()};
            case ($urandom_range(0, 3))
                0: ;                                            // full width
                1: value = value >> $urandom_range(1, 63);      // shorter runs
                2: value = -(value >> $urandom_range(1, 63));   // negatives of shorter magnitude
                default: value = 64'($urandom_range(0, 20));    // one or two digits
            endcase
            push_number(value, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence: reset once, then three idling phases
    // ------------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender mostly busy, receiver often stalled
        send_idle_pct = 7;
        recv_idle_pct = 45;
        test_zero();
        test_extremes();
        test_digit_boundaries();
        test_random_numbers(52);

        // sender often idle, receiver mostly ready
        send_idle_pct = 45;
        recv_idle_pct = 7;
        test_random_numbers(52);

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_numbers(52);

        // drop valid, collect what is owed, then watch for stray words
        i_s_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Converted %0d numbers, %0d characters checked, %0d mismatches.",
                 numbers_sent, chars_checked, error_count);
        $display("Covered zero, sign extremes, 20-digit runs and random lengths.");
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
